>>> design/mrce_pkg.sv
// Shared types, constants and the CRC-16 byte step for the memory range checksum engine.
// Has no dependencies; the datapath and the top level import it.
package mrce_pkg;

   localparam logic [1:0] MODE_BYTE_SUM = 2'd0;
   localparam logic [1:0] MODE_WORD_SUM = 2'd1;
   localparam logic [1:0] MODE_CRC16    = 2'd2;
   localparam logic [1:0] MODE_RESET    = MODE_CRC16;

   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef struct packed {
      logic [31:0] accumulator;
      logic [23:0] partial_word;
      logic [1:0]  byte_lane;
   } check_state_type;

   localparam check_state_type STATE_CLEAR = '0;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] r;
      r = {8'h00, crc[7:0] ^ b};
      for (int k = 0; k < 8; k++) begin
         if (r[0]) begin
            r = (r >> 1) ^ CRC_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r ^ {8'h00, crc[15:8]};
   endfunction

endpackage

>>> design/memory_range_checksum_engine.sv
// Top level of the memory range checksum engine: input stage, running state and result register.
// Depends on mrce_pkg and mrce_datapath.
//
// The engine takes one memory byte per cycle and returns one 32-bit check value for each
// range from the result register, loaded when the last byte leaves the input register.
// The check mode register selects a byte sum, a little-endian word sum or a reflected CRC-16;
// it resets to CRC-16. Throughput is one byte per cycle, set by the update of the running
// accumulator through one CRC byte step or one 32-bit add. A held result only stalls the
// input when another last byte is waiting behind it.
module memory_range_checksum_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_check_value
);
   import mrce_pkg::*;

   logic [1:0]      mode_ff;
   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   check_state_type state_ff;
   check_state_type state_in;
   logic            out_valid_ff;
   logic [31:0]     out_value_ff;
   logic [31:0]     value_in;
   logic            advance;
   logic            out_free;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !advance;

   mrce_datapath u_datapath (
      .state_cur   (state_ff),
      .check_mode  (mode_ff),
      .data_byte   (in_byte_ff),
      .last        (in_last_ff),
      .state_next  (state_in),
      .check_value (value_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_CLEAR;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         out_value_ff <= value_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_check_value = out_value_ff;

endmodule

>>> design/mrce_datapath.sv
// Next-state and result logic for one byte beat of the checksum engine.
// Depends on mrce_pkg for the state struct, the mode codes and the CRC step.
module mrce_datapath (
   input  mrce_pkg::check_state_type state_cur,
   input  logic [1:0]                check_mode,
   input  logic [7:0]                data_byte,
   input  logic                      last,
   output mrce_pkg::check_state_type state_next,
   output logic [31:0]               check_value
);
   import mrce_pkg::*;

   check_state_type updated;
   logic [23:0]     merged;

   always_comb begin
      merged = state_cur.partial_word;
      case (state_cur.byte_lane)
         2'd0:    merged[7:0]   = merged[7:0]   | data_byte;
         2'd1:    merged[15:8]  = merged[15:8]  | data_byte;
         2'd2:    merged[23:16] = merged[23:16] | data_byte;
         default: merged        = state_cur.partial_word;
      endcase
   end

   always_comb begin
      updated     = state_cur;
      check_value = '0;
      case (check_mode)
         MODE_BYTE_SUM: begin
            updated.accumulator = state_cur.accumulator + {24'h000000, data_byte};
            check_value         = updated.accumulator;
         end
         MODE_WORD_SUM: begin
            if (state_cur.byte_lane == 2'd3) begin
               updated.accumulator  = state_cur.accumulator
                                      + {data_byte, state_cur.partial_word};
               updated.partial_word = '0;
               updated.byte_lane    = 2'd0;
               check_value          = updated.accumulator;
            end else begin
               updated.partial_word = merged;
               updated.byte_lane    = state_cur.byte_lane + 2'd1;
               check_value          = state_cur.accumulator + {8'h00, merged};
            end
         end
         default: begin
            updated.accumulator = {16'h0000, crc16_byte(state_cur.accumulator[15:0], data_byte)};
            check_value         = updated.accumulator;
         end
      endcase
   end

   assign state_next = last ? STATE_CLEAR : updated;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for memory_range_checksum_engine: directed ranges, then random ones,
// checked against a predictor of the byte sum, word sum and CRC-16 checks.
// Depends on mrce_pkg and the engine RTL.
module testbench;
   import mrce_pkg::*;

   localparam logic [1:0] MODE_CRC16_ALT = 2'd3;
   localparam int         RANDOM_BEATS   = 1925;

   class range_check_tracker;
      logic [1:0]  mode;
      logic [31:0] acc;
      logic [23:0] partial;
      logic [1:0]  lane;
      logic [31:0] expected_checks[$];
      int          mismatches;

      function new();
         mode = MODE_RESET;
         acc = '0;
         partial = '0;
         lane = '0;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_checks.size();
      endfunction

      function logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         logic        fb;
         c = crc;
         for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb) begin
               c = c ^ 16'hA001;
            end
         end
         return c;
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         logic [31:0] sum;
         logic [23:0] shifted;
         case (mode)
            MODE_BYTE_SUM: begin
               acc = acc + {24'h0, b};
               sum = acc;
            end
            MODE_WORD_SUM: begin
               if (lane == 2'd3) begin
                  acc = acc + {b, partial};
                  partial = '0;
                  lane = 2'd0;
               end else begin
                  shifted = {16'h0, b} << (8 * lane);
                  partial = partial | shifted;
                  lane = lane + 2'd1;
               end
               sum = (lane != 2'd0) ? acc + {8'h0, partial} : acc;
            end
            default: begin
               acc = {16'h0, crc_update(acc[15:0], b)};
               sum = acc;
            end
         endcase
         if (last) begin
            expected_checks.push_back(sum);
            acc = '0;
            partial = '0;
            lane = '0;
         end
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: %s", msg);
         end
      endfunction

      function void check_result(logic [31:0] actual);
         logic [31:0] want;
         if (expected_checks.size() == 0) begin
            flag($sformatf("unexpected check_value %08h", actual));
         end else begin
            want = expected_checks.pop_front();
            if (actual !== want) begin
               flag($sformatf("check_value expected %08h actual %08h", want, actual));
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_check_value;

   range_check_tracker tracker;
   int beats_sent;
   int burst_left;

   memory_range_checksum_engine uut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_check_value(rsp_check_value)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_beat(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid = 1'b1;
      req_data_byte = b;
      req_last = last;
      do @(posedge clock); while (req_stall);
      tracker.note_byte(b, last);
      beats_sent++;
      @(negedge clock);
   endtask

   // The engine must be idle for a mode write, so drain all results first.
   task automatic set_mode(input logic [1:0] m);
      req_valid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_wr_data = m;
      @(negedge clock);
      csr_wr_en = 1'b0;
      tracker.mode = m;
   endtask

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) begin
         return 8'h00;
      end else if (r == 1) begin
         return 8'hFF;
      end
      return 8'($urandom);
   endfunction

   task automatic send_range(input int len, input bit switch_inside);
      int cut;
      cut = $urandom_range(1, len);
      for (int i = 0; i < len; i++) begin
         if (switch_inside && i == cut && i < len) begin
            set_mode(2'($urandom_range(0, 3)));
         end
         send_beat(pick_byte(), i == len - 1);
      end
   endtask

   initial begin
      int style;
      int count;
      rsp_stall = 1'b0;
      style = 0;
      count = 0;
      forever begin
         @(negedge clock);
         if (count == 0) begin
            style = $urandom_range(0, 4);
            count = $urandom_range(50, 250);
         end
         count--;
         case (style)
            0: rsp_stall = 1'b0;
            1: rsp_stall = ($urandom_range(0, 3) == 0);
            2: rsp_stall = ($urandom_range(0, 3) != 0);
            3: rsp_stall = (count % 7) < 3;
            default: rsp_stall = (count % 40) < 25;
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_result(rsp_check_value);
      end
   end

   initial begin
      int len;
      tracker = new();
      beats_sent = 0;
      burst_left = 0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = MODE_BYTE_SUM;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_last = 1'b0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // CRC-16 straight out of reset.
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h80, 1'b0);
      send_beat(8'h01, 1'b1);
      set_mode(MODE_BYTE_SUM);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b1);
      send_beat(8'h00, 1'b1);
      // Word sum: a full word plus a one-byte tail, a lone byte, and a three-byte tail.
      set_mode(MODE_WORD_SUM);
      send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h01, 1'b1);
      send_beat(8'hAB, 1'b1);
      send_beat(8'h12, 1'b0);
      send_beat(8'h34, 1'b0);
      send_beat(8'h56, 1'b1);
      // The unused mode code behaves as CRC-16.
      set_mode(MODE_CRC16_ALT);
      send_beat(8'hA5, 1'b0);
      send_beat(8'h5A, 1'b1);
      // Mode changes inside one range share the accumulator and the pending word.
      set_mode(MODE_WORD_SUM);
      send_beat(8'h11, 1'b0);
      send_beat(8'h22, 1'b0);
      set_mode(MODE_CRC16);
      send_beat(8'h33, 1'b0);
      set_mode(MODE_BYTE_SUM);
      send_beat(8'h44, 1'b0);
      set_mode(MODE_WORD_SUM);
      send_beat(8'h55, 1'b0);
      send_beat(8'h66, 1'b1);

      while (beats_sent < RANDOM_BEATS) begin
         if ($urandom_range(0, 7) == 0) begin
            set_mode(2'($urandom_range(0, 3)));
         end
         if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(13, 64);
         end else begin
            len = $urandom_range(1, 12);
         end
         send_range(len, len > 1 && $urandom_range(0, 11) == 0);
      end

      req_valid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/mrce_pkg.sv
design/mrce_datapath.sv
design/memory_range_checksum_engine.sv
dv/testbench.sv
